>>> hdl/tscaz_pkg.sv
// Shared types and constants for the three-phase current sense block.
// Holds the pipeline control record, channel codes and the fixed field widths.
// Depends on nothing.
package tscaz_pkg;

	// Default parameter values.
	localparam int CAL_SAMPLES_DEF = 100;
	localparam int SAMPLE_BITS_DEF = 12;

	// Fixed widths of the port fields.
	localparam int NUM_CH    = 3;
	localparam int CH_W      = 2;
	localparam int GAIN_W    = 24;
	localparam int CUR_W     = 21;
	localparam int FRAC_W    = 8;
	localparam int CUR_SHIFT = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd67584;

	// Channel codes.
	localparam logic [CH_W-1:0] CH_A    = 2'd0;
	localparam logic [CH_W-1:0] CH_B    = 2'd1;
	localparam logic [CH_W-1:0] CH_C    = 2'd2;
	localparam logic [CH_W-1:0] CH_NONE = 2'd3;

	// Saturation limits of a current in signed Q.16 amps.
	localparam logic signed [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
	localparam logic signed [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};

	// Control record that travels with each request down the pipeline.
	typedef struct packed {
		logic            vld;
		logic [CH_W-1:0] ch;
		logic            use_cur;
		logic            fin;
		logic            calib;
		logic            snap;
	} tscaz_ctl_t;

endpackage

>>> hdl/tscaz_cal.sv
// Calibration bookkeeping: per-channel sample sums, counts and done flags.
// Decides what each request does downstream and registers it into stage two.
// Depends on tscaz_pkg.
module tscaz_cal import tscaz_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                en,
	input  logic                                                vld_s1,
	input  logic [CH_W-1:0]                                     ch_s1,
	input  logic [SAMPLE_BITS-1:0]                              smp_s1,
	output tscaz_ctl_t                                          ctl_s2,
	output logic [SAMPLE_BITS-1:0]                              smp_s2,
	output logic [SAMPLE_BITS+$clog2(CAL_SAMPLES+1)-1:0]        sum_s2
);

	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	logic [SUM_W-1:0]  sum_q [NUM_CH];
	logic [CNT_W-1:0]  cnt_q [NUM_CH];
	logic [NUM_CH-1:0] done_q;

	logic [SUM_W-1:0]  sum_nxt [NUM_CH];
	logic [CNT_W-1:0]  cnt_nxt [NUM_CH];
	logic [NUM_CH-1:0] sel;
	logic [NUM_CH-1:0] hit;
	logic [NUM_CH-1:0] fin;
	logic [NUM_CH-1:0] done_nxt;
	logic [SUM_W-1:0]  sum_sel;
	tscaz_ctl_t        ctl;

	// Accumulate the sample of a channel that is still calibrating.
	always_comb begin
		sum_sel = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			sel[i]     = vld_s1 && (ch_s1 == CH_W'(i));
			hit[i]     = sel[i] && !done_q[i];
			sum_nxt[i] = sum_q[i] + SUM_W'(smp_s1);
			cnt_nxt[i] = cnt_q[i] + CNT_W'(1);
			fin[i]     = hit[i] && (cnt_nxt[i] == CNT_W'(CAL_SAMPLES));
			if (hit[i]) begin
				sum_sel = sum_nxt[i];
			end
		end
		done_nxt    = done_q | fin;
		ctl.vld     = vld_s1;
		ctl.ch      = ch_s1;
		ctl.use_cur = |(sel & done_q);
		ctl.fin     = |fin;
		ctl.calib   = &done_nxt;
		ctl.snap    = vld_s1 && (ch_s1 == CH_A) && (&done_nxt);
	end

	// Per-channel calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			done_q <= '0;
		end else if (en) begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (hit[i]) begin
					sum_q[i] <= sum_nxt[i];
					cnt_q[i] <= cnt_nxt[i];
				end
			end
			done_q <= done_nxt;
		end
	end

	// Stage two control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl;
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s2 <= smp_s1;
			sum_s2 <= sum_sel;
		end
	end

endmodule

>>> hdl/tscaz_ofs.sv
// Zero-offset divider and offset store. Divides the calibration sum by the
// sample count with reciprocal multiplies, then removes the offset from samples.
// Depends on tscaz_pkg.
module tscaz_ofs import tscaz_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  tscaz_ctl_t                                    ctl_s2,
	input  logic [SAMPLE_BITS-1:0]                        smp_s2,
	input  logic [SAMPLE_BITS+$clog2(CAL_SAMPLES+1)-1:0]  sum_s2,
	output tscaz_ctl_t                                    ctl_s5,
	output logic signed [SAMPLE_BITS+FRAC_W:0]            diff_s5
);

	localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int OFS_W  = SAMPLE_BITS + FRAC_W;
	localparam int DIFF_W = OFS_W + 1;

	// Reciprocal for the whole-count quotient, exact for every sum in range.
	localparam int S1   = SUM_W + CNT_W;
	localparam int M1_W = S1 + 1;
	localparam longint unsigned M1_L =
		((64'd1 << S1) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [M1_W-1:0] M1 = M1_W'(M1_L);
	localparam int Q1_W = SUM_W + M1_W;

	// Reciprocal for the rounded fraction bits of the remainder.
	localparam int X2_W = CNT_W + FRAC_W + 1;
	localparam int S2   = X2_W + CNT_W;
	localparam int M2_W = S2 + 1;
	localparam longint unsigned M2_L =
		((64'd1 << S2) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [M2_W-1:0] M2 = M2_W'(M2_L);
	localparam int F2_W = X2_W + M2_W;

	tscaz_ctl_t             ctl_s3;
	tscaz_ctl_t             ctl_s4;
	logic [SAMPLE_BITS-1:0] smp_s3;
	logic [SAMPLE_BITS-1:0] smp_s4;
	logic [SAMPLE_BITS-1:0] q_s3;
	logic [SAMPLE_BITS-1:0] q_s4;
	logic [SUM_W-1:0]       sum_s3;
	logic [CNT_W-1:0]       r_s4;
	logic [OFS_W-1:0]       zero_ofs_q [NUM_CH];

	logic [Q1_W-1:0]        qprod;
	logic [SUM_W-1:0]       r_full;
	logic [X2_W-1:0]        x2;
	logic [F2_W-1:0]        fprod;
	logic [OFS_W-1:0]       ofs_new;
	logic [OFS_W-1:0]       ofs_sel;
	logic [DIFF_W-1:0]      diff_nxt;

	// Stage two: quotient of the sum by the sample count.
	assign qprod = Q1_W'(sum_s2) * Q1_W'(M1);

	// Stage three: remainder left by the quotient.
	assign r_full = sum_s3 - SUM_W'(q_s3) * SUM_W'(CAL_SAMPLES);

	// Stage four: fraction bits rounded half up, and offset removal.
	assign x2      = (X2_W'(r_s4) << FRAC_W) + X2_W'(CAL_SAMPLES / 2);
	assign fprod   = F2_W'(x2) * F2_W'(M2);
	assign ofs_new = {q_s4, fprod[S2 +: FRAC_W]};

	always_comb begin
		case (ctl_s4.ch)
			CH_A:    ofs_sel = zero_ofs_q[0];
			CH_B:    ofs_sel = zero_ofs_q[1];
			CH_C:    ofs_sel = zero_ofs_q[2];
			default: ofs_sel = '0;
		endcase
	end

	assign diff_nxt = DIFF_W'({smp_s4, {FRAC_W{1'b0}}}) - DIFF_W'(ofs_sel);

	// Offset store, written by the request that completes calibration.
	always_ff @(posedge clk) begin
		if (en && ctl_s4.fin) begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (ctl_s4.ch == CH_W'(i)) begin
					zero_ofs_q[i] <= ofs_new;
				end
			end
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s3  <= smp_s2;
			sum_s3  <= sum_s2;
			q_s3    <= qprod[S1 +: SAMPLE_BITS];
			smp_s4  <= smp_s3;
			q_s4    <= q_s3;
			r_s4    <= r_full[CNT_W-1:0];
			diff_s5 <= diff_nxt;
		end
	end

endmodule

>>> hdl/tscaz_scale.sv
// Current scaling: multiplies the offset-free sample by the gain, then rounds
// half away from zero to signed Q.16 amps and saturates to the field range.
// Depends on tscaz_pkg.
module tscaz_scale import tscaz_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  tscaz_ctl_t                         ctl_s5,
	input  logic signed [SAMPLE_BITS+FRAC_W:0] diff_s5,
	input  logic [GAIN_W-1:0]                  gain,
	output tscaz_ctl_t                         ctl_s6,
	output logic signed [CUR_W-1:0]            cur
);

	localparam int DIFF_W   = SAMPLE_BITS + FRAC_W + 1;
	localparam int PROD_W   = DIFF_W + GAIN_W + 1;
	localparam int RND_W    = PROD_W + 1;
	localparam int RND_HALF = 1 << (CUR_SHIFT - 1);
	localparam int CUR_LIM  = 1 << (CUR_W - 1);

	logic signed [PROD_W-1:0] prod_nxt;
	logic signed [PROD_W-1:0] prod_s6;
	logic                     neg;
	logic [PROD_W-1:0]        mag;
	logic [RND_W-1:0]         rnd;

	// Stage five: signed product in Q.32 amps.
	assign prod_nxt = $signed(diff_s5) * $signed({1'b0, gain});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6 <= prod_nxt;
		end
	end

	// Stage six: round the magnitude, restore the sign and saturate.
	assign neg = prod_s6[PROD_W-1];
	assign mag = neg ? PROD_W'(-prod_s6) : PROD_W'(prod_s6);
	assign rnd = (RND_W'(mag) + RND_W'(RND_HALF)) >> CUR_SHIFT;

	always_comb begin
		if (neg) begin
			if (rnd > RND_W'(CUR_LIM)) begin
				cur = CUR_MIN;
			end else begin
				cur = CUR_W'(RND_W'(0) - rnd);
			end
		end else begin
			if (rnd > RND_W'(CUR_LIM - 1)) begin
				cur = CUR_MAX;
			end else begin
				cur = CUR_W'(rnd);
			end
		end
	end

endmodule

>>> hdl/three_phase_current_sense_autozero.sv
// Three-phase current sense with automatic zero-offset calibration.
// Top level: input register, gain register, current and snapshot registers.
// Depends on tscaz_pkg, tscaz_cal, tscaz_ofs and tscaz_scale.
//
// The block takes one ADC conversion request per clock while the output side
// does not stall, and returns one result per request. It is a seven-register
// pipeline (input register, five work stages, result register) that moves as a
// whole whenever the result register is empty or being taken, so the sustained
// rate is one request per cycle while results are taken. The first CAL_SAMPLES
// conversions of each channel set its zero offset, and the next conversion on
// that channel already uses it. Channel code three is passed through with no
// effect on calibration or current state. The gain register may be written in
// any cycle that no request is in flight; writes are always accepted.
module three_phase_current_sense_autozero import tscaz_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     calibrated,
	output logic                     snapshot_taken,
	output logic signed [CUR_W-1:0]  current_a,
	output logic signed [CUR_W-1:0]  current_b,
	output logic signed [CUR_W-1:0]  current_c,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [GAIN_W-1:0]        amps_per_lsb
);

	localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int DIFF_W = SAMPLE_BITS + FRAC_W + 1;

	logic                       en;
	logic                       vld_s1;
	logic [CH_W-1:0]            ch_s1;
	logic [SAMPLE_BITS-1:0]     smp_s1;
	tscaz_ctl_t                 ctl_s2;
	tscaz_ctl_t                 ctl_s5;
	tscaz_ctl_t                 ctl_s6;
	logic [SAMPLE_BITS-1:0]     smp_s2;
	logic [SUM_W-1:0]           sum_s2;
	logic signed [DIFF_W-1:0]   diff_s5;
	logic signed [CUR_W-1:0]    cur;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [CUR_W-1:0]    latest_q   [NUM_CH];
	logic signed [CUR_W-1:0]    latest_nxt [NUM_CH];
	logic signed [CUR_W-1:0]    snap_q     [NUM_CH];
	logic                       out_vld_q;
	logic                       calib_q;
	logic                       taken_q;

	// The whole pipeline advances when the result register can take a new value.
	assign en        = !out_vld_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= amps_per_lsb;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ch_s1  <= channel;
			smp_s1 <= sample;
		end
	end

	tscaz_cal #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_s1 (vld_s1),
		.ch_s1  (ch_s1),
		.smp_s1 (smp_s1),
		.ctl_s2 (ctl_s2),
		.smp_s2 (smp_s2),
		.sum_s2 (sum_s2)
	);

	tscaz_ofs #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_ofs (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s2  (ctl_s2),
		.smp_s2  (smp_s2),
		.sum_s2  (sum_s2),
		.ctl_s5  (ctl_s5),
		.diff_s5 (diff_s5)
	);

	tscaz_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s5  (ctl_s5),
		.diff_s5 (diff_s5),
		.gain    (gain_q),
		.ctl_s6  (ctl_s6),
		.cur     (cur)
	);

	// Latest currents including the request in the last stage.
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (ctl_s6.use_cur && (ctl_s6.ch == CH_W'(i))) begin
				latest_nxt[i] = cur;
			end else begin
				latest_nxt[i] = latest_q[i];
			end
		end
	end

	// Latest currents, snapshot and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				latest_q[i] <= '0;
				snap_q[i]   <= '0;
			end
			out_vld_q <= 1'b0;
			calib_q   <= 1'b0;
			taken_q   <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_s6.vld;
			if (ctl_s6.vld) begin
				latest_q <= latest_nxt;
				if (ctl_s6.snap) begin
					snap_q <= latest_nxt;
				end
				calib_q <= ctl_s6.calib;
				taken_q <= ctl_s6.snap;
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign calibrated     = calib_q;
	assign snapshot_taken = taken_q;
	assign current_a      = snap_q[0];
	assign current_b      = snap_q[1];
	assign current_c      = snap_q[2];

endmodule
